FILE: rtl/nv12p_pkg.sv
// nv12p_pkg: shared types, constants and helpers for the nv12 pair to rgba block
// depends on nothing; imported by every module in rtl/
package nv12p_pkg;

  // field widths
  localparam int unsigned SampleW = 8;
  localparam int unsigned PixelW  = 32;
  localparam int unsigned CfgIdxW = 4;

  // signed working widths
  localparam int unsigned ScaledW = 18;  // (y-16)*298, y*256, d*292, d*256
  localparam int unsigned OffW    = 19;  // chroma offsets after the floor shift
  localparam int unsigned SumW    = 20;  // luma plus offset plus rounding
  localparam int unsigned ProdW   = 28;  // scaled chroma times coefficient

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRangeFull   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSwapRedBlue = CfgIdxW'(1);

  // conversion constants
  localparam logic signed [10:0] LumaScaleLim   = 11'sd298;
  localparam logic signed [10:0] ChromaScaleLim = 11'sd292;
  localparam logic signed [10:0] ScaleFull      = 11'sd256;
  localparam logic signed [10:0] CoefRv         = 11'sd403;
  localparam logic signed [10:0] CoefGu         = 11'sd48;
  localparam logic signed [10:0] CoefGv         = 11'sd120;
  localparam logic signed [10:0] CoefBu         = 11'sd475;
  localparam logic signed [9:0]  LumaOffset     = 10'sd16;
  localparam logic signed [9:0]  ChromaOffset   = 10'sd128;
  localparam logic signed [SumW-1:0] RoundHalf  = SumW'(128);
  localparam logic [SampleW-1:0] AlphaOpaque    = 8'hFF;

  // per stage advance strobes shared by chroma unit and lanes
  typedef struct packed {
    logic s0;  // input transfer into stage 0
    logic s1;  // stage 0 to stage 1
    logic s2;  // stage 1 into the output register
  } adv_t;

  // chroma offsets that every lane adds
  typedef struct packed {
    logic signed [OffW-1:0] r;
    logic signed [OffW-1:0] g;
    logic signed [OffW-1:0] b;
  } offs_t;

  // floor shift by 8 then clamp to 0..255
  function automatic logic [SampleW-1:0] clamp_chan(input logic signed [SumW-1:0] s);
    logic signed [SumW-9:0] q;
    logic [SampleW-1:0] r;
    q = s[SumW-1:8];
    if (q[SumW-9]) begin
      r = '0;
    end else if (q[SumW-10:SampleW] != '0) begin
      r = AlphaOpaque;
    end else begin
      r = q[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/nv12p_chroma.sv
// nv12p_chroma: two stage chroma path, scaled u/v then the r, g, b offsets
// depends on nv12p_pkg
module nv12p_chroma (
  input  logic                          clk_i,
  input  nv12p_pkg::adv_t               adv_i,
  input  logic                          range_full_i,
  input  logic [nv12p_pkg::SampleW-1:0] chroma_u_i,
  input  logic [nv12p_pkg::SampleW-1:0] chroma_v_i,
  output nv12p_pkg::offs_t              offs_o
);
  import nv12p_pkg::*;

  logic signed [9:0]         du, dv;
  logic signed [10:0]        scale;
  logic signed [ScaledW-1:0] us_d, vs_d, us_q, vs_q;
  logic signed [ProdW-1:0]   p_rv, p_gu, p_gv, p_bu;
  offs_t                     offs_d, offs_q;

  // stage 0: remove offset and scale
  assign du    = $signed({2'b00, chroma_u_i}) - ChromaOffset;
  assign dv    = $signed({2'b00, chroma_v_i}) - ChromaOffset;
  assign scale = range_full_i ? ScaleFull : ChromaScaleLim;
  assign us_d  = ScaledW'(du * scale);
  assign vs_d  = ScaledW'(dv * scale);

  always_ff @(posedge clk_i) begin
    if (adv_i.s0) begin
      us_q <= us_d;
      vs_q <= vs_d;
    end
  end

  // stage 1: coefficient products, floor shift by 8 via bit select
  assign p_rv = ProdW'(vs_q * CoefRv);
  assign p_gu = ProdW'(us_q * CoefGu);
  assign p_gv = ProdW'(vs_q * CoefGv);
  assign p_bu = ProdW'(us_q * CoefBu);

  assign offs_d.r = p_rv[OffW+7:8];
  assign offs_d.g = -p_gu[OffW+7:8] - p_gv[OffW+7:8];
  assign offs_d.b = p_bu[OffW+7:8];

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      offs_q <= offs_d;
    end
  end

  assign offs_o = offs_q;

endmodule

FILE: rtl/nv12p_lane.sv
// nv12p_lane: one pixel lane, luma scaling then round, clamp and pack
// depends on nv12p_pkg
module nv12p_lane (
  input  logic                          clk_i,
  input  nv12p_pkg::adv_t               adv_i,
  input  logic                          range_full_i,
  input  logic                          swap_red_blue_i,
  input  logic [nv12p_pkg::SampleW-1:0] luma_i,
  input  nv12p_pkg::offs_t              offs_i,
  output logic [nv12p_pkg::PixelW-1:0]  pixel_o
);
  import nv12p_pkg::*;

  logic signed [9:0]         yd;
  logic signed [ScaledW-1:0] ys_d, ys0_q, ys1_q;
  logic signed [SumW-1:0]    sum_r, sum_g, sum_b;
  logic [SampleW-1:0]        ch_r, ch_g, ch_b, lo, hi;
  logic [PixelW-1:0]         pixel_d, pixel_q;

  // stage 0: scaled luma
  assign yd   = $signed({2'b00, luma_i}) - LumaOffset;
  assign ys_d = range_full_i ? $signed({2'b00, luma_i, 8'h00})
                             : ScaledW'(yd * LumaScaleLim);

  always_ff @(posedge clk_i) begin
    if (adv_i.s0) begin
      ys0_q <= ys_d;
    end
    if (adv_i.s1) begin
      ys1_q <= ys0_q;
    end
  end

  // stage 2: add chroma offsets with rounding, clamp each channel
  assign sum_r = SumW'(ys1_q) + SumW'(offs_i.r) + RoundHalf;
  assign sum_g = SumW'(ys1_q) + SumW'(offs_i.g) + RoundHalf;
  assign sum_b = SumW'(ys1_q) + SumW'(offs_i.b) + RoundHalf;

  assign ch_r = clamp_chan(sum_r);
  assign ch_g = clamp_chan(sum_g);
  assign ch_b = clamp_chan(sum_b);

  // byte order select
  assign lo      = swap_red_blue_i ? ch_b : ch_r;
  assign hi      = swap_red_blue_i ? ch_r : ch_b;
  assign pixel_d = {AlphaOpaque, hi, ch_g, lo};

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      pixel_q <= pixel_d;
    end
  end

  assign pixel_o = pixel_q;

endmodule

FILE: rtl/nv12_pair_to_rgba.sv
// nv12_pair_to_rgba: top level, handshake pipeline, config registers, lane merge
// depends on nv12p_pkg, nv12p_chroma, nv12p_lane
//
// Converts one NV12 pixel pair (two luma bytes sharing one U and one V byte)
// into two packed BT.709 RGBA pixels, alpha 255, with red in byte 0 unless
// swap_red_blue is set. The block takes one pair per clock while in_stall_o is low,
// through three register stages: one scales luma and chroma and is loaded at the
// input transfer, one forms the chroma offsets from the coefficient multipliers,
// and one rounds, clamps and packs into the output register. Two lanes convert
// the two pixels side by side from the shared chroma offsets; a pair with
// second_valid low comes out with pixel_second zero. in_stall_o is raised only
// when every stage holds a pair and the output is stalled. Configuration
// (index 0 range_full, index 1 swap_red_blue, others ignored) is always
// ready and must be written while no pair is in flight.
module nv12_pair_to_rgba (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nv12p_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic                          cfg_data_i,
  // input pairs
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [nv12p_pkg::SampleW-1:0] luma_first_i,
  input  logic [nv12p_pkg::SampleW-1:0] luma_second_i,
  input  logic [nv12p_pkg::SampleW-1:0] chroma_u_i,
  input  logic [nv12p_pkg::SampleW-1:0] chroma_v_i,
  input  logic                          second_valid_i,
  // output pixels
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [nv12p_pkg::PixelW-1:0]  pixel_first_o,
  output logic [nv12p_pkg::PixelW-1:0]  pixel_second_o,
  output logic                          second_present_o
);
  import nv12p_pkg::*;

  logic        range_full_q, swap_red_blue_q;
  logic        v0_q, v1_q, vo_q;
  logic        pres0_q, pres1_q, preso_q;
  logic        rdy0, rdy1, rdy2;
  adv_t        adv;
  offs_t       offs;
  logic [PixelW-1:0] pix_a, pix_b;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_full_q    <= 1'b0;
      swap_red_blue_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegRangeFull:   range_full_q    <= cfg_data_i;
        RegSwapRedBlue: swap_red_blue_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage ready chain, a stage takes new data when empty or moving on
  assign rdy2       = !vo_q || !out_stall_i;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;

  assign adv.s0 = in_valid_i && rdy0;
  assign adv.s1 = v0_q && rdy1;
  assign adv.s2 = v1_q && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) vo_q <= v1_q;
    end
  end

  // second pixel flag travels with the pair
  always_ff @(posedge clk_i) begin
    if (adv.s0) pres0_q <= second_valid_i;
    if (adv.s1) pres1_q <= pres0_q;
    if (adv.s2) preso_q <= pres1_q;
  end

  // shared chroma offsets
  nv12p_chroma u_chroma (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .range_full_i (range_full_q),
    .chroma_u_i   (chroma_u_i),
    .chroma_v_i   (chroma_v_i),
    .offs_o       (offs)
  );

  // left and right pixel lanes
  nv12p_lane u_lane_first (
    .clk_i           (clk_i),
    .adv_i           (adv),
    .range_full_i    (range_full_q),
    .swap_red_blue_i (swap_red_blue_q),
    .luma_i          (luma_first_i),
    .offs_i          (offs),
    .pixel_o         (pix_a)
  );

  nv12p_lane u_lane_second (
    .clk_i           (clk_i),
    .adv_i           (adv),
    .range_full_i    (range_full_q),
    .swap_red_blue_i (swap_red_blue_q),
    .luma_i          (luma_second_i),
    .offs_i          (offs),
    .pixel_o         (pix_b)
  );

  // merge lanes, drop the right pixel at an odd row tail
  assign out_valid_o      = vo_q;
  assign pixel_first_o    = pix_a;
  assign pixel_second_o   = preso_q ? pix_b : '0;
  assign second_present_o = preso_q;

  // an input stall only arises with the pipeline full and the output stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v0_q && v1_q && vo_q && out_stall_i))
    else $error("input stalled while pipeline has room");

  // a missing right pixel reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !second_present_o) |-> (pixel_second_o == '0))
    else $error("absent right pixel not zeroed");

  // an accepted pair reaches stage 0 on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v0_q)
    else $error("accepted pair lost at stage 0");

  // a stage 1 pair with an open output lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && (!vo_q || !out_stall_i)) |=> out_valid_o)
    else $error("pair lost entering output register");

endmodule
